// File: hw/rtl/hgr_pkg.sv
// ----------------------------------------------------------------------------
// hgr_pkg: shared constants and types of the hsv gradient color block
// Fixed-point formats, register codes and the structs passed between the
// config registers, the interpolation pipe and the hsv to rgb pipe.
// ----------------------------------------------------------------------------
package hgr_pkg;

  localparam int FRAC_BITS  = 8;
  localparam int UNIT_FRAC  = 8;
  localparam int POS_W      = 12;
  localparam int RANGE_W    = 12;
  localparam int HUE_W      = 9;
  localparam int UNIT_W     = 9;
  localparam int BASE_W     = 9;
  localparam int DIFF_W     = 9;
  localparam int CHAN_W     = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;
  localparam int NUM_LANES  = 3;
  localparam int SEC_W      = 3;

  localparam int LANE_HUE = 0;
  localparam int LANE_SAT = 1;
  localparam int LANE_VAL = 2;

  // interpolated hue, saturation and value width; 1.0 fits too
  localparam int XW         = DIFF_W + FRAC_BITS;
  localparam int QW         = XW;
  localparam int PROD_W     = POS_W + DIFF_W;
  localparam int NUM_W      = PROD_W + FRAC_BITS;
  localparam int UNIT_SHIFT = UNIT_FRAC + FRAC_BITS;

  localparam int HUE_DEG_MAX = 360;
  localparam int UNIT_ONE    = 256;
  localparam int SECTOR_DEG  = 60;
  localparam int SECTORS     = 6;
  localparam int CHAN_MAX    = 255;

  localparam int SPAN    = SECTOR_DEG << FRAC_BITS;
  localparam int REM_W   = 6 + FRAC_BITS;
  localparam int FW      = UNIT_FRAC + FRAC_BITS;

  // fraction = remainder * 2^8 / 60 as a reciprocal multiply and shift
  localparam int DIV60_SHIFT = REM_W + 6;
  localparam int DIV60_MUL_W = REM_W + 9;
  localparam logic [DIV60_MUL_W-1:0] DIV60_MUL =
    DIV60_MUL_W'(((64'd1 << (REM_W + 14)) + SECTOR_DEG - 1) / SECTOR_DEG);

  localparam logic [XW-1:0]     ONE      = XW'(1) << UNIT_SHIFT;
  localparam logic [XW-1:0]     HUE_TOP  = XW'(HUE_DEG_MAX) << FRAC_BITS;
  localparam logic [HUE_W-1:0]  HUE_MAX  = HUE_W'(HUE_DEG_MAX);
  localparam logic [UNIT_W-1:0] UNIT_MAX = UNIT_W'(UNIT_ONE);

  localparam logic [HUE_W-1:0]   TOP_HUE_RST = 9'd0;
  localparam logic [UNIT_W-1:0]  TOP_SAT_RST = 9'd256;
  localparam logic [UNIT_W-1:0]  TOP_VAL_RST = 9'd256;
  localparam logic [HUE_W-1:0]   BOT_HUE_RST = 9'd245;
  localparam logic [UNIT_W-1:0]  BOT_SAT_RST = 9'd256;
  localparam logic [UNIT_W-1:0]  BOT_VAL_RST = 9'd256;
  localparam logic [RANGE_W-1:0] RANGE_RST   = 12'd300;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TOP_HUE = 3'd0,
    REG_TOP_SAT = 3'd1,
    REG_TOP_VAL = 3'd2,
    REG_BOT_HUE = 3'd3,
    REG_BOT_SAT = 3'd4,
    REG_BOT_VAL = 3'd5,
    REG_RANGE   = 3'd6
  } reg_idx_t;

  typedef enum logic [SEC_W-1:0] {
    SEC_RY = 3'd0,
    SEC_YG = 3'd1,
    SEC_GC = 3'd2,
    SEC_CB = 3'd3,
    SEC_BM = 3'd4,
    SEC_MR = 3'd5
  } sector_t;

  typedef struct packed {
    logic              up;
    logic [DIFF_W-1:0] diff;
    logic [BASE_W-1:0] base;
  } lane_cfg_t;

  typedef struct packed {
    lane_cfg_t [NUM_LANES-1:0] lane;
    logic [RANGE_W-1:0]        range;
  } cfg_t;

  typedef struct packed {
    logic          valid;
    logic [XW-1:0] hue;
    logic [XW-1:0] sat;
    logic [XW-1:0] val;
  } hsv_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic valid;
    rgb_t color;
  } pix_t;

endpackage

// File: hw/rtl/hgr_ifs.sv
// ----------------------------------------------------------------------------
// hgr_ifs: request channels of the hsv gradient color block
// Position requests in, color results out, register writes in.
// ----------------------------------------------------------------------------
interface hgr_pos_if;
  logic                      valid;
  logic                      ready;
  logic [hgr_pkg::POS_W-1:0] position;

  modport source (output valid, output position, input ready);
  modport sink (input valid, input position, output ready);
endinterface

interface hgr_rgb_if;
  logic                       valid;
  logic                       ready;
  logic [hgr_pkg::CHAN_W-1:0] red;
  logic [hgr_pkg::CHAN_W-1:0] green;
  logic [hgr_pkg::CHAN_W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
endinterface

interface hgr_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [hgr_pkg::CFG_IDX_W-1:0]  index;
  logic [hgr_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/hgr_cfg_regs.sv
// ----------------------------------------------------------------------------
// hgr_cfg_regs: configuration registers
// Holds the end colors and the range, limited on write, and derives the
// per-lane start value, step magnitude and direction.
// ----------------------------------------------------------------------------
module hgr_cfg_regs (
  input  logic          clk,
  input  logic          rst,
  hgr_cfg_if.sink       wr,
  output hgr_pkg::cfg_t cfg
);
  import hgr_pkg::*;

  logic [HUE_W-1:0]   top_hue;
  logic [UNIT_W-1:0]  top_sat;
  logic [UNIT_W-1:0]  top_val;
  logic [HUE_W-1:0]   bot_hue;
  logic [UNIT_W-1:0]  bot_sat;
  logic [UNIT_W-1:0]  bot_val;
  logic [RANGE_W-1:0] range;
  logic [HUE_W-1:0]   hue_in;
  logic [UNIT_W-1:0]  unit_in;
  logic [RANGE_W-1:0] range_in;

  function automatic lane_cfg_t lane_of(input logic [BASE_W-1:0] top,
                                        input logic [BASE_W-1:0] bot);
    lane_cfg_t l;
    l.up   = bot >= top;
    l.diff = l.up ? DIFF_W'(bot - top) : DIFF_W'(top - bot);
    l.base = top;
    return l;
  endfunction

  assign wr.ready = 1'b1;

  assign hue_in   = (wr.data[HUE_W-1:0] > HUE_MAX) ? HUE_MAX : wr.data[HUE_W-1:0];
  assign unit_in  = (wr.data[UNIT_W-1:0] > UNIT_MAX) ? UNIT_MAX : wr.data[UNIT_W-1:0];
  assign range_in = (wr.data[RANGE_W-1:0] == '0) ? RANGE_W'(1) : wr.data[RANGE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      top_hue <= TOP_HUE_RST;
      top_sat <= TOP_SAT_RST;
      top_val <= TOP_VAL_RST;
      bot_hue <= BOT_HUE_RST;
      bot_sat <= BOT_SAT_RST;
      bot_val <= BOT_VAL_RST;
      range   <= RANGE_RST;
    end else if (wr.valid) begin
      unique case (reg_idx_t'(wr.index))
        REG_TOP_HUE: top_hue <= hue_in;
        REG_TOP_SAT: top_sat <= unit_in;
        REG_TOP_VAL: top_val <= unit_in;
        REG_BOT_HUE: bot_hue <= hue_in;
        REG_BOT_SAT: bot_sat <= unit_in;
        REG_BOT_VAL: bot_val <= unit_in;
        REG_RANGE:   range   <= range_in;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.lane[LANE_HUE] = lane_of(top_hue, bot_hue);
    cfg.lane[LANE_SAT] = lane_of(top_sat, bot_sat);
    cfg.lane[LANE_VAL] = lane_of(top_val, bot_val);
    cfg.range          = range;
  end

endmodule

// File: hw/rtl/hgr_lerp.sv
// ----------------------------------------------------------------------------
// hgr_lerp: gradient interpolation pipe
// Limits the position, scales each lane's step by it and divides by the
// range one quotient bit per stage, then adds or subtracts from the start.
// ----------------------------------------------------------------------------
module hgr_lerp (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  hgr_pkg::cfg_t             cfg,
  input  logic                      in_valid,
  input  logic [hgr_pkg::POS_W-1:0] in_pos,
  output hgr_pkg::hsv_t             hsv
);
  import hgr_pkg::*;

  localparam int RW = NUM_W - QW;

  logic              s1_valid;
  logic [POS_W-1:0]  s1_pos;
  logic [QW:0]       d_valid;
  logic [RW-1:0]     d_rem [QW+1][NUM_LANES];
  logic [QW-1:0]     d_low [QW+1][NUM_LANES];
  logic [QW-1:0]     d_quo [QW+1][NUM_LANES];
  logic [PROD_W-1:0] prod [NUM_LANES];
  logic [NUM_W-1:0]  num [NUM_LANES];
  logic [XW-1:0]     x [NUM_LANES];

  // position limit
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_pos <= (in_pos > cfg.range) ? cfg.range : in_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= '0;
    end else if (en) begin
      d_valid <= {d_valid[QW-1:0], s1_valid};
    end
  end

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    assign prod[l] = PROD_W'(s1_pos) * PROD_W'(cfg.lane[l].diff);
    assign num[l]  = {prod[l], {FRAC_BITS{1'b0}}};

    // upper numerator bits are already below the range
    always_ff @(posedge clk) begin
      if (en) begin
        d_rem[0][l] <= num[l][NUM_W-1:QW];
        d_low[0][l] <= num[l][QW-1:0];
        d_quo[0][l] <= '0;
      end
    end

    for (genvar k = 1; k <= QW; k++) begin : g_step
      logic [RW:0] trial;
      logic        fits;

      assign trial = {d_rem[k-1][l], d_low[k-1][l][QW-1]};
      assign fits  = trial >= {1'b0, cfg.range};

      always_ff @(posedge clk) begin
        if (en) begin
          d_rem[k][l] <= fits ? RW'(trial - {1'b0, cfg.range}) : trial[RW-1:0];
          d_low[k][l] <= {d_low[k-1][l][QW-2:0], 1'b0};
          d_quo[k][l] <= {d_quo[k-1][l][QW-2:0], fits};
        end
      end
    end

    assign x[l] = cfg.lane[l].up ?
                  {cfg.lane[l].base, {FRAC_BITS{1'b0}}} + d_quo[QW][l] :
                  {cfg.lane[l].base, {FRAC_BITS{1'b0}}} - d_quo[QW][l];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hsv.valid <= 1'b0;
    end else if (en) begin
      hsv.valid <= d_valid[QW];
      hsv.hue   <= x[LANE_HUE];
      hsv.sat   <= x[LANE_SAT];
      hsv.val   <= x[LANE_VAL];
    end
  end

endmodule

// File: hw/rtl/hgr_hsv2rgb.sv
// ----------------------------------------------------------------------------
// hgr_hsv2rgb: hsv to rgb conversion pipe
// Splits hue into sector and remainder, scales the remainder to a fraction
// by a reciprocal multiply, forms p, q and t over two multiply stages and
// scales the selected terms to 8-bit channels.
// ----------------------------------------------------------------------------
module hgr_hsv2rgb (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  hgr_pkg::hsv_t hsv,
  output hgr_pkg::pix_t pix
);
  import hgr_pkg::*;

  localparam int CW = XW + CHAN_W - UNIT_SHIFT;
  localparam int DW = DIV60_SHIFT + FW;

  sector_t            sec;
  logic [XW-1:0]      base;
  logic [REM_W-1:0]   rem;
  logic [XW-1:0]      sat_c;
  logic [XW-1:0]      val_c;

  logic               a_valid;
  sector_t            a_sec;
  logic [REM_W-1:0]   a_rem;
  logic [XW-1:0]      a_sat;
  logic [XW-1:0]      a_val;

  logic [DW-1:0]      f_full;
  logic               f_valid;
  logic [FW-1:0]      f_quo;
  sector_t            f_sec;
  logic [XW-1:0]      f_sat;
  logic [XW-1:0]      f_val;

  logic [FW+XW-1:0]   fs_full;
  logic [2*XW-1:0]    gs_full;
  logic [2*XW-1:0]    p_full;
  logic               m_valid;
  sector_t            m_sec;
  logic [XW-1:0]      m_fs;
  logic [XW-1:0]      m_gs;
  logic [XW-1:0]      m_p;
  logic [XW-1:0]      m_val;

  logic [2*XW-1:0]    q_full;
  logic [2*XW-1:0]    t_full;
  logic               n_valid;
  sector_t            n_sec;
  logic [XW-1:0]      n_p;
  logic [XW-1:0]      n_q;
  logic [XW-1:0]      n_t;
  logic [XW-1:0]      n_val;

  logic [XW-1:0]      r_sel;
  logic [XW-1:0]      g_sel;
  logic [XW-1:0]      b_sel;

  function automatic logic [CHAN_W-1:0] to_chan(input logic [XW-1:0] xv);
    logic [XW+CHAN_W-1:0] scaled;
    logic [CW-1:0]        c;
    scaled = (XW+CHAN_W)'(xv) * (XW+CHAN_W)'(CHAN_MAX);
    c      = scaled[XW+CHAN_W-1:UNIT_SHIFT];
    return (c > CW'(CHAN_MAX)) ? CHAN_W'(CHAN_MAX) : c[CHAN_W-1:0];
  endfunction

  // sector search over five independent compares
  always_comb begin
    sec  = SEC_RY;
    base = '0;
    for (int k = 1; k < SECTORS; k++) begin
      if (hsv.hue >= XW'(k * SPAN)) begin
        sec  = sector_t'(SEC_W'(k));
        base = XW'(k * SPAN);
      end
    end
    // full circle wraps to red
    if (hsv.hue >= XW'(SECTORS * SPAN)) begin
      sec  = SEC_RY;
      base = hsv.hue;
    end
  end

  assign rem   = REM_W'(hsv.hue - base);
  assign sat_c = (hsv.sat > ONE) ? ONE : hsv.sat;
  assign val_c = (hsv.val > ONE) ? ONE : hsv.val;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= hsv.valid;
      a_sec   <= sec;
      a_rem   <= rem;
      a_sat   <= sat_c;
      a_val   <= val_c;
    end
  end

  // exact over the whole remainder range
  assign f_full = DW'(a_rem) * DW'(DIV60_MUL);

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (en) begin
      f_valid <= a_valid;
      f_quo   <= f_full[DIV60_SHIFT +: FW];
      f_sec   <= a_sec;
      f_sat   <= a_sat;
      f_val   <= a_val;
    end
  end

  // f*s, (1-f)*s and p
  assign fs_full = (FW+XW)'(f_quo) * (FW+XW)'(f_sat);
  assign gs_full = (2*XW)'(ONE - XW'(f_quo)) * (2*XW)'(f_sat);
  assign p_full  = (2*XW)'(f_val) * (2*XW)'(ONE - f_sat);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (en) begin
      m_valid <= f_valid;
      m_sec   <= f_sec;
      m_fs    <= XW'(fs_full >> UNIT_SHIFT);
      m_gs    <= XW'(gs_full >> UNIT_SHIFT);
      m_p     <= XW'(p_full >> UNIT_SHIFT);
      m_val   <= f_val;
    end
  end

  // q and t
  assign q_full = (2*XW)'(m_val) * (2*XW)'(ONE - m_fs);
  assign t_full = (2*XW)'(m_val) * (2*XW)'(ONE - m_gs);

  always_ff @(posedge clk) begin
    if (rst) begin
      n_valid <= 1'b0;
    end else if (en) begin
      n_valid <= m_valid;
      n_sec   <= m_sec;
      n_p     <= m_p;
      n_q     <= XW'(q_full >> UNIT_SHIFT);
      n_t     <= XW'(t_full >> UNIT_SHIFT);
      n_val   <= m_val;
    end
  end

  always_comb begin
    case (n_sec)
      SEC_RY: begin
        r_sel = n_val; g_sel = n_t;   b_sel = n_p;
      end
      SEC_YG: begin
        r_sel = n_q;   g_sel = n_val; b_sel = n_p;
      end
      SEC_GC: begin
        r_sel = n_p;   g_sel = n_val; b_sel = n_t;
      end
      SEC_CB: begin
        r_sel = n_p;   g_sel = n_q;   b_sel = n_val;
      end
      SEC_BM: begin
        r_sel = n_t;   g_sel = n_p;   b_sel = n_val;
      end
      default: begin
        r_sel = n_val; g_sel = n_p;   b_sel = n_q;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pix.valid <= 1'b0;
    end else if (en) begin
      pix.valid       <= n_valid;
      pix.color.red   <= to_chan(r_sel);
      pix.color.green <= to_chan(g_sel);
      pix.color.blue  <= to_chan(b_sel);
    end
  end

endmodule

// File: hw/rtl/hsv_gradient_to_rgb.sv
// ----------------------------------------------------------------------------
// hsv_gradient_to_rgb: color bar generator
// Interpolates hsv between two configured colors by position and converts
// the result to 8-bit rgb.
//
//   channel   dir   payload                 request
//   pos       in    position (12)           one position along the bar
//   rgb       out   red, green, blue (8)    one color per position
//   reg_wr    in    index (3), data (12)    one register write
//
// One position per cycle while pos.ready is high. A color reaches the output
// register through the position limit stage, the range divider pipe with one
// quotient bit a stage, and the hsv to rgb stages.
// Reset clears all valid bits and loads the default colors and range.
// A two-entry output buffer keeps pos.ready registered: it drops only when
// both entries are full, and then the whole pipe holds.
// ----------------------------------------------------------------------------
module hsv_gradient_to_rgb (
  input  logic      clk,
  input  logic      rst,
  hgr_pos_if.sink   pos,
  hgr_rgb_if.source rgb,
  hgr_cfg_if.sink   reg_wr
);
  import hgr_pkg::*;

  cfg_t cfg;
  hsv_t hsv;
  pix_t pix;
  logic en;
  logic take;
  logic out_valid;
  logic skid_valid;
  rgb_t out_color;
  rgb_t skid_color;

  assign en        = !skid_valid;
  assign pos.ready = en;
  assign take      = out_valid && rgb.ready;

  hgr_cfg_regs u_cfg (
    .clk (clk),
    .rst (rst),
    .wr  (reg_wr),
    .cfg (cfg)
  );

  hgr_lerp u_lerp (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .cfg      (cfg),
    .in_valid (pos.valid),
    .in_pos   (pos.position),
    .hsv      (hsv)
  );

  hgr_hsv2rgb u_conv (
    .clk (clk),
    .rst (rst),
    .en  (en),
    .hsv (hsv),
    .pix (pix)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid || take) begin
        out_valid  <= skid_valid || (en && pix.valid);
        skid_valid <= 1'b0;
      end else if (en && pix.valid) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || take) begin
      out_color <= skid_valid ? skid_color : pix.color;
    end else if (en && pix.valid) begin
      skid_color <= pix.color;
    end
  end

  assign rgb.valid = out_valid;
  assign rgb.red   = out_color.red;
  assign rgb.green = out_color.green;
  assign rgb.blue  = out_color.blue;

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry without output entry");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && !rgb.ready))
    else $error("skid filled while output was free");

  a_range_nonzero: assert property (@(posedge clk) disable iff (rst)
    cfg.range != '0)
    else $error("zero gradient range");

  a_hsv_bounds: assert property (@(posedge clk) disable iff (rst)
    hsv.valid |-> (hsv.hue <= HUE_TOP) && (hsv.sat <= ONE) && (hsv.val <= ONE))
    else $error("interpolated hsv out of bounds");
`endif

endmodule
